>>> rtl/core/lapic_pkg.sv
package lapic_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MISALIGNED  = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic [1:0] TMR_ONESHOT  = 2'd0;
  localparam logic [1:0] TMR_PERIODIC = 2'd1;
  localparam logic [1:0] TMR_DEADLINE = 2'd2;
  localparam logic [1:0] TMR_RESERVED = 2'd3;

  localparam logic [11:0] OFF_ID       = 12'h020;
  localparam logic [11:0] OFF_VERSION  = 12'h030;
  localparam logic [11:0] OFF_EOI      = 12'h0b0;
  localparam logic [11:0] OFF_LDR      = 12'h0d0;
  localparam logic [11:0] OFF_DFR      = 12'h0e0;
  localparam logic [11:0] OFF_SVR      = 12'h0f0;
  localparam logic [11:0] OFF_ZERO_LO  = 12'h100;
  localparam logic [11:0] OFF_ZERO_HI  = 12'h270;
  localparam logic [11:0] OFF_ESR      = 12'h280;
  localparam logic [11:0] OFF_LVT_CMCI = 12'h2f0;
  localparam logic [11:0] OFF_ICR_LO   = 12'h300;
  localparam logic [11:0] OFF_ICR_HI   = 12'h310;
  localparam logic [11:0] OFF_LVT_TMR  = 12'h320;
  localparam logic [11:0] OFF_LVT_THM  = 12'h330;
  localparam logic [11:0] OFF_LVT_PMC  = 12'h340;
  localparam logic [11:0] OFF_LVT_LI0  = 12'h350;
  localparam logic [11:0] OFF_LVT_LI1  = 12'h360;
  localparam logic [11:0] OFF_LVT_ERR  = 12'h370;
  localparam logic [11:0] OFF_INIT_CNT = 12'h380;
  localparam logic [11:0] OFF_CUR_CNT  = 12'h390;
  localparam logic [11:0] OFF_DIV_CFG  = 12'h3e0;

  localparam logic [31:0] VERSION_VALUE = 32'h0006_0015;

  localparam int unsigned NUM_PLAIN = 11;

  typedef struct packed {
    logic        tick;
    logic        lvt_we;
    logic        mode_we;
    logic        init_we;
    logic        div_we;
    logic [31:0] wdata;
  } tmr_ctl_t;

  typedef struct packed {
    logic [7:0]  vector;
    logic        masked;
    logic [1:0]  mode;
    logic [2:0]  shift;
    logic [31:0] initial_count;
    logic [31:0] current_count;
    logic        irq;
  } tmr_stat_t;

endpackage

>>> rtl/core/lapic_timer.sv
module lapic_timer (
  input  logic                 clk,
  input  logic                 rst,
  input  lapic_pkg::tmr_ctl_t  ctl,
  output lapic_pkg::tmr_stat_t stat
);
  import lapic_pkg::*;

  logic [7:0]  vector;
  logic        masked;
  logic [1:0]  mode;
  logic [2:0]  shift;
  logic [31:0] initial_count;
  logic [31:0] current_count;
  logic [6:0]  prescale_count;

  logic [7:0] last_wide;
  logic [6:0] last;
  logic       running;
  logic       pre_done;
  logic       expire;

  assign last_wide = (8'd1 << shift) - 8'd1;
  assign last      = last_wide[6:0];
  assign running   = ctl.tick && (mode == TMR_ONESHOT || mode == TMR_PERIODIC) &&
                     (current_count != 32'd0);
  assign pre_done  = prescale_count >= last;
  assign expire    = running && pre_done && (current_count == 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vector         <= '0;
      masked         <= 1'b0;
      mode           <= TMR_ONESHOT;
      shift          <= '0;
      initial_count  <= '0;
      current_count  <= '0;
      prescale_count <= '0;
    end else begin
      if (running) begin
        if (!pre_done) begin
          prescale_count <= prescale_count + 7'd1;
        end else begin
          prescale_count <= '0;
          if (current_count > 32'd1) begin
            current_count <= current_count - 32'd1;
          end else begin
            current_count <= (mode == TMR_PERIODIC) ? initial_count : 32'd0;
          end
        end
      end
      if (ctl.lvt_we) begin
        vector <= ctl.wdata[7:0];
        masked <= ctl.wdata[16];
      end
      if (ctl.mode_we) begin
        mode <= ctl.wdata[18:17];
      end
      if (ctl.init_we) begin
        initial_count  <= ctl.wdata;
        current_count  <= ctl.wdata;
        prescale_count <= '0;
      end
      if (ctl.div_we) begin
        shift <= {ctl.wdata[3], ctl.wdata[1:0]} + 3'd1;
      end
    end
  end

  assign stat.vector        = vector;
  assign stat.masked        = masked;
  assign stat.mode          = mode;
  assign stat.shift         = shift;
  assign stat.initial_count = initial_count;
  assign stat.current_count = current_count;
  assign stat.irq           = expire && !masked;

endmodule

>>> rtl/core/local_apic_registers_and_timer_unit.sv
// a request passes through the input register and then the result register
// throughput: one request per cycle while results are taken, reads, writes and timer ticks alike
// the timer state and register file update as a request leaves the input register
// rst (synchronous, active high) clears all registers, the timer and apic_id
// and empties both pipeline registers
module local_apic_registers_and_timer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // offset[11:0], write_data[43:12], zero fill
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // read_data[31:0], status[33:32], irq_valid[34],
                                      // irq_vector[42:35], zero fill
);
  import lapic_pkg::*;

  logic [31:0] apic_id;
  logic [31:0] plain_regs [NUM_PLAIN];

  logic        in_valid;
  logic [1:0]  in_op;
  logic [11:0] in_offset;
  logic [31:0] in_wdata;

  logic        out_valid;
  logic [31:0] out_read_data;
  logic [1:0]  out_status;
  logic        out_irq_valid;
  logic [7:0]  out_irq_vector;

  logic        advance;
  logic        plain_hit;
  logic [3:0]  plain_idx;
  logic        plain_we;
  logic [31:0] rd_data;
  logic [1:0]  st;
  tmr_ctl_t    dec_ctl;
  tmr_ctl_t    tmr_ctl;
  tmr_stat_t   tmr_stat;
  logic [2:0]  div_enc;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    plain_hit = 1'b1;
    plain_idx = 4'd0;
    unique case (in_offset)
      OFF_LDR:      plain_idx = 4'd0;
      OFF_DFR:      plain_idx = 4'd1;
      OFF_SVR:      plain_idx = 4'd2;
      OFF_LVT_CMCI: plain_idx = 4'd3;
      OFF_ICR_LO:   plain_idx = 4'd4;
      OFF_ICR_HI:   plain_idx = 4'd5;
      OFF_LVT_THM:  plain_idx = 4'd6;
      OFF_LVT_PMC:  plain_idx = 4'd7;
      OFF_LVT_LI0:  plain_idx = 4'd8;
      OFF_LVT_LI1:  plain_idx = 4'd9;
      OFF_LVT_ERR:  plain_idx = 4'd10;
      default:      plain_hit = 1'b0;
    endcase
  end

  assign div_enc = tmr_stat.shift - 3'd1;

  always_comb begin
    rd_data       = '0;
    st            = ST_OK;
    plain_we      = 1'b0;
    dec_ctl       = '0;
    dec_ctl.wdata = in_wdata;
    if (in_op == OP_TICK) begin
      dec_ctl.tick = 1'b1;
    end else if (in_op != OP_READ && in_op != OP_WRITE) begin
      st = ST_UNSUPPORTED;
    end else if (in_offset[3:0] != 4'd0) begin
      st = ST_MISALIGNED;
    end else if (in_op == OP_READ) begin
      if (plain_hit) begin
        rd_data = plain_regs[plain_idx];
      end else if ((in_offset >= OFF_ZERO_LO && in_offset <= OFF_ZERO_HI) ||
                   in_offset == OFF_ESR) begin
        rd_data = '0;
      end else begin
        unique case (in_offset)
          OFF_ID:       rd_data = apic_id;
          OFF_VERSION:  rd_data = VERSION_VALUE;
          OFF_LVT_TMR:  rd_data = {13'd0, tmr_stat.mode, tmr_stat.masked, 8'd0,
                                   tmr_stat.vector};
          OFF_INIT_CNT: rd_data = tmr_stat.initial_count;
          OFF_CUR_CNT:  rd_data = (tmr_stat.mode == TMR_DEADLINE ||
                                   tmr_stat.mode == TMR_RESERVED) ?
                                  32'd0 : tmr_stat.current_count;
          OFF_DIV_CFG:  rd_data = {28'd0, div_enc[2], 1'b0, div_enc[1:0]};
          default:      st = ST_UNSUPPORTED;
        endcase
      end
    end else begin
      if (plain_hit) begin
        plain_we = 1'b1;
      end else begin
        unique case (in_offset)
          OFF_EOI, OFF_ESR: st = ST_OK;
          OFF_ID: begin
            if (in_wdata != apic_id) begin
              st = ST_UNSUPPORTED;
            end
          end
          OFF_LVT_TMR: begin
            dec_ctl.lvt_we = 1'b1;
            if (in_wdata[18:17] == TMR_RESERVED) begin
              st = ST_UNSUPPORTED;
            end else begin
              dec_ctl.mode_we = 1'b1;
            end
          end
          OFF_INIT_CNT: dec_ctl.init_we = 1'b1;
          OFF_DIV_CFG:  dec_ctl.div_we  = 1'b1;
          default:      st = ST_UNSUPPORTED;
        endcase
      end
    end
  end

  always_comb begin
    tmr_ctl         = dec_ctl;
    tmr_ctl.tick    = dec_ctl.tick    && advance;
    tmr_ctl.lvt_we  = dec_ctl.lvt_we  && advance;
    tmr_ctl.mode_we = dec_ctl.mode_we && advance;
    tmr_ctl.init_we = dec_ctl.init_we && advance;
    tmr_ctl.div_we  = dec_ctl.div_we  && advance;
  end

  lapic_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .ctl  (tmr_ctl),
    .stat (tmr_stat)
  );

  // register file and config
  always_ff @(posedge clk) begin
    if (rst) begin
      apic_id <= '0;
      for (int i = 0; i < NUM_PLAIN; i++) begin
        plain_regs[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        apic_id <= cfg_wdata;
      end
      if (advance && plain_we) begin
        plain_regs[plain_idx] <= in_wdata;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op     <= s_axis_tuser;
      in_offset <= s_axis_tdata[11:0];
      in_wdata  <= s_axis_tdata[43:12];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_read_data  <= (st == ST_OK) ? rd_data : 32'd0;
      out_status     <= st;
      out_irq_valid  <= tmr_stat.irq && dec_ctl.tick;
      out_irq_vector <= (tmr_stat.irq && dec_ctl.tick) ? tmr_stat.vector : 8'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_irq_vector, out_irq_valid, out_status, out_read_data};

  a_irq_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_irq_valid |-> out_status == ST_OK && out_read_data == 32'd0)
    else $error("interrupt result carries data or error status");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid && out_valid && !m_axis_tready)
    else $error("input stalled without a blocked result");

  a_deadline_hold: assert property (@(posedge clk) disable iff (rst)
    tmr_stat.mode == TMR_DEADLINE && !tmr_ctl.init_we |=>
      $stable(tmr_stat.current_count))
    else $error("counter moved in deadline mode");

endmodule
